[src/wmf_pkg.sv]
// Shared types and constants of the window median filter.
`timescale 1ns / 1ps

package wmf_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIX_W       = NUM_CHAN * SAMPLE_W;
  localparam int WIN_SIDE    = 3;
  localparam int WIN_TAPS    = WIN_SIDE * WIN_SIDE;
  localparam int MED_IDX     = WIN_TAPS / 2;
  localparam int SORT_STAGES = WIN_TAPS;

  localparam int ROW_W       = 12;
  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NUM_CHAN-1:0] pixel_t;
  typedef pixel_t [WIN_SIDE-1:0] column_t;                  // row 0 is the oldest row
  typedef sample_t [NUM_CHAN-1:0][WIN_TAPS-1:0] win_t;      // per channel, 9 taps

  typedef struct packed {
    logic valid;
    logic frame_end;
  } stage_ctrl_t;

endpackage

[src/wmf_line_ram.sv]
// Single line buffer: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps

module wmf_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 24,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-cycle write to the read address returns the new data
  always_ff @(posedge clk) begin
    if (en) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

[src/wmf_sort_cell.sv]
// One odd-even transposition stage of the 9-tap sorter, all channels.
`timescale 1ns / 1ps

module wmf_sort_cell import wmf_pkg::*; #(
  parameter bit ODD = 1'b0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  stage_ctrl_t in_ctrl,
  input  win_t        in_win,
  output stage_ctrl_t out_ctrl,
  output win_t        out_win
);

  win_t swapped;

  always_comb begin
    swapped = in_win;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      for (int i = (ODD ? 1 : 0); i + 1 < WIN_TAPS; i += 2) begin
        if (in_win[ch][i] > in_win[ch][i+1]) begin
          swapped[ch][i]   = in_win[ch][i+1];
          swapped[ch][i+1] = in_win[ch][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else if (en) begin
      out_ctrl.valid <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl.frame_end <= in_ctrl.frame_end;
      out_win            <= swapped;
    end
  end

endmodule

[src/window_median_filter_core.sv]
// Top level of the streaming 3x3 median filter for 3-channel pixels.
//
// Channels: in (command + three samples), out (three medians + frame_end),
// cfg (register index + data; index 0 image_width, 1 image_height), all
// valid/ready. cfg_ready is always high; a register write restarts the frame
// and drops pending results. Write only while the block is idle.
// Pixels arrive in raster order. The result for a pixel is triggered by the
// pixel one row and one column later; at frame end each flush item triggers
// one of the remaining results. Window taps outside the image are left out.
// Throughput: one item per clock unless the receiver stalls. The only bubble is
// in_ready low after the last pixel of a one-row frame, used to align the window.
// Pipeline: 12 register stages (line buffer read, window capture, nine sorter
// cells, output register); the first loads at the accepting edge, and a
// triggered result passes through the rest in order to the output.
// A stalled receiver freezes the whole pipeline; in_ready follows out_ready.
// Reset clears control state and loads 512 x 512; line buffers are not
// cleared (taps from unwritten rows are always masked).
`timescale 1ns / 1ps

module window_median_filter_core import wmf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [7:0]           chan0_in,
  input  logic [7:0]           chan1_in,
  input  logic [7:0]           chan2_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           chan0_out,
  output logic [7:0]           chan1_out,
  output logic [7:0]           chan2_out,
  output logic                 frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);      // column / line buffer address
  localparam int WW = $clog2(MAX_WIDTH + 1);  // effective width
  localparam int PW = $clog2(MAX_WIDTH + 3);  // pending count, up to lag; pending + 1 also fits
  localparam int XW = ((WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W) + 1;

  // ---------------------------------------------------------------- config
  logic [CFG_WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]       image_height;
  logic [WW-1:0]          ew;
  logic [ROW_W-1:0]       eh;
  logic [PW-1:0]          lag;
  logic                   cfg_accept;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_comb begin
    if (image_width == '0) begin
      ew = WW'(1);
    end else if (XW'(image_width) > XW'(MAX_WIDTH)) begin
      ew = WW'(MAX_WIDTH);
    end else begin
      ew = WW'(image_width);
    end
  end

  assign eh  = (image_height == '0) ? ROW_W'(1) : image_height;
  assign lag = PW'(ew) + PW'(1);

  // ------------------------------------------------------- stage 0: control
  logic [CW-1:0]    in_column, in_column_next;
  logic [ROW_W:0]   in_row, in_row_next;       // runs past the frame while draining
  logic [CW-1:0]    out_column, out_column_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [PW-1:0]    pending, pending_next;
  logic             catchup;                   // one silent advance after a one-row frame
  logic             catchup_next;

  logic             adv;                       // whole pipeline moves
  logic             accept, is_pixel, done, restart_now, drain, issue, emit;
  logic [CW-1:0]    cur_in_col, cur_out_col;
  logic [ROW_W:0]   cur_in_row;
  logic [ROW_W-1:0] cur_out_row;
  logic [PW-1:0]    cur_pending;
  logic             in_col_last, out_col_last;
  logic [WIN_SIDE-1:0] row_ok, col_ok;
  logic [WIN_TAPS-1:0] tap_valid, tap_low;
  logic             cur_frame_end;
  logic [3:0]       n_valid, low_lim, n_inv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !catchup;
  assign accept   = in_valid && in_ready;
  assign is_pixel = (command == CMD_PIXEL);
  assign done     = (in_row >= {1'b0, eh});

  assign restart_now = accept && is_pixel && done;
  assign drain       = (command == CMD_FLUSH) && done && (pending != '0);
  assign issue       = (accept && (is_pixel || drain)) || (catchup && adv);

  assign cur_in_col  = restart_now ? '0 : in_column;
  assign cur_in_row  = restart_now ? '0 : in_row;
  assign cur_out_col = restart_now ? '0 : out_column;
  assign cur_out_row = restart_now ? '0 : out_row;
  assign cur_pending = restart_now ? '0 : pending;

  assign emit = accept && (is_pixel ? ((cur_pending + PW'(1)) > lag) : drain);

  assign in_col_last  = ((WW'(cur_in_col) + WW'(1)) == ew);
  assign out_col_last = ((WW'(cur_out_col) + WW'(1)) == ew);

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = cur_out_col;
    out_row_next    = cur_out_row;
    pending_next    = pending;
    catchup_next    = catchup;
    if (issue) begin
      if (in_col_last) begin
        in_column_next = '0;
        in_row_next    = cur_in_row + (ROW_W+1)'(1);
      end else begin
        in_column_next = cur_in_col + CW'(1);
        in_row_next    = cur_in_row;
      end
      pending_next = cur_pending + PW'(is_pixel && accept) - PW'(emit);
      catchup_next = accept && is_pixel && (eh == ROW_W'(1)) && in_col_last;
    end
    if (emit) begin
      if (out_col_last) begin
        out_column_next = '0;
        out_row_next    = cur_out_row + ROW_W'(1);
      end else begin
        out_column_next = cur_out_col + CW'(1);
        out_row_next    = cur_out_row;
      end
    end
  end

  // Tap mask for the window centered at the current output position.
  // Missing taps are padded with 0 and 255 so that the middle of nine sorted
  // values is the sorted valid sample at index count/2.
  always_comb begin
    row_ok[0] = (cur_out_row != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = ({1'b0, cur_out_row} + (ROW_W+1)'(1)) < {1'b0, eh};
    col_ok[0] = (cur_out_col != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = !out_col_last;
    n_valid   = '0;
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < WIN_SIDE; c++) begin
        tap_valid[r*WIN_SIDE+c] = row_ok[r] && col_ok[c];
        n_valid = n_valid + 4'(row_ok[r] && col_ok[c]);
      end
    end
    low_lim = 4'(MED_IDX) - (n_valid >> 1);
    n_inv   = '0;
    for (int j = 0; j < WIN_TAPS; j++) begin
      tap_low[j] = !tap_valid[j] && (n_inv < low_lim);
      n_inv      = n_inv + 4'(!tap_valid[j]);
    end
    cur_frame_end = (cur_out_row == (eh - ROW_W'(1))) && out_col_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_W'(512);
      image_height <= ROW_W'(512);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      pending      <= '0;
      catchup      <= 1'b0;
    end else if (cfg_accept) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
      if ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        pending    <= '0;
        catchup    <= 1'b0;
      end
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      pending    <= pending_next;
      catchup    <= catchup_next;
    end
  end

  // ------------------------------------------- stage 1: line buffer read
  logic                s1_valid;
  logic                s1_emit;
  logic                s1_frame_end;
  logic [CW-1:0]       s1_addr;
  pixel_t              s1_pix;
  logic [WIN_TAPS-1:0] s1_tap_valid, s1_tap_low;
  logic [PIX_W-1:0]    upper_rd, lower_rd;
  logic                line_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit      <= emit;
      s1_frame_end <= cur_frame_end;
      s1_addr      <= cur_in_col;
      s1_pix       <= {chan2_in, chan1_in, chan0_in};
      s1_tap_valid <= tap_valid;
      s1_tap_low   <= tap_low;
    end
  end

  assign line_we = s1_valid && adv;

  // lower holds the row above the incoming pixel, upper the row above that
  wmf_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W), .AW(CW)) u_lower_line (
    .clk   (clk),
    .en    (adv),
    .we    (line_we),
    .waddr (s1_addr),
    .wdata (s1_pix),
    .raddr (cur_in_col),
    .rdata (lower_rd)
  );

  wmf_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(PIX_W), .AW(CW)) u_upper_line (
    .clk   (clk),
    .en    (adv),
    .we    (line_we),
    .waddr (s1_addr),
    .wdata (lower_rd),
    .raddr (cur_in_col),
    .rdata (upper_rd)
  );

  // ------------------------------------ stage 2: window columns and capture
  column_t     col_old, col_mid, col_new;
  column_t     win_cols [WIN_SIDE];
  win_t        s2_win, win_form;
  stage_ctrl_t s2_ctrl;

  assign col_new = {s1_pix, pixel_t'(lower_rd), pixel_t'(upper_rd)};

  always_ff @(posedge clk) begin
    if (line_we) begin
      col_old <= col_mid;
      col_mid <= col_new;
    end
  end

  assign win_cols[0] = col_old;
  assign win_cols[1] = col_mid;
  assign win_cols[2] = col_new;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      for (int r = 0; r < WIN_SIDE; r++) begin
        for (int c = 0; c < WIN_SIDE; c++) begin
          if (s1_tap_valid[r*WIN_SIDE+c]) begin
            win_form[ch][r*WIN_SIDE+c] = win_cols[c][r][ch];
          end else if (s1_tap_low[r*WIN_SIDE+c]) begin
            win_form[ch][r*WIN_SIDE+c] = '0;
          end else begin
            win_form[ch][r*WIN_SIDE+c] = '1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl.valid <= 1'b0;
    end else if (adv) begin
      s2_ctrl.valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctrl.frame_end <= s1_frame_end;
      s2_win            <= win_form;
    end
  end

  // -------------------------------------------------- sorter cell chain
  stage_ctrl_t cell_ctrl [SORT_STAGES+1];
  win_t        cell_win  [SORT_STAGES+1];

  assign cell_ctrl[0] = s2_ctrl;
  assign cell_win[0]  = s2_win;

  for (genvar g = 0; g < SORT_STAGES; g++) begin : g_sort
    wmf_sort_cell #(.ODD(1'(g % 2))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_ctrl  (cell_ctrl[g]),
      .in_win   (cell_win[g]),
      .out_ctrl (cell_ctrl[g+1]),
      .out_win  (cell_win[g+1])
    );
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cell_ctrl[SORT_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chan0_out <= cell_win[SORT_STAGES][0][MED_IDX];
      chan1_out <= cell_win[SORT_STAGES][1][MED_IDX];
      chan2_out <= cell_win[SORT_STAGES][2][MED_IDX];
      frame_end <= cell_ctrl[SORT_STAGES].frame_end;
    end
  end

endmodule
